@@ hdl/sbt_pkg.sv @@
// shared types, token codes and character helpers for the source byte tokenizer
package sbt_pkg;

  localparam int OFFSET_BITS_DEF   = 16;
  localparam int KEYWORD_BYTES_DEF = 8;
  localparam int MAX_RESULTS       = 3;
  localparam int KW_COUNT          = 9;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_IDENT   = 4'd1,
    M_INT     = 4'd2,
    M_DOT     = 4'd3,
    M_FRAC    = 4'd4,
    M_STR     = 4'd5,
    M_SLASH   = 4'd6,
    M_COMMENT = 4'd7,
    M_OP      = 4'd8
  } scan_mode_t;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_UNEXP   = 6'd1;
  localparam logic [5:0] K_UNTERM  = 6'd2;
  localparam logic [5:0] K_IDENT   = 6'd3;
  localparam logic [5:0] K_NUMBER  = 6'd4;
  localparam logic [5:0] K_STRING  = 6'd5;
  localparam logic [5:0] K_KW_BASE = 6'd6;
  localparam logic [5:0] K_LPAREN  = 6'd15;
  localparam logic [5:0] K_RPAREN  = 6'd16;
  localparam logic [5:0] K_LBRACE  = 6'd17;
  localparam logic [5:0] K_RBRACE  = 6'd18;
  localparam logic [5:0] K_LBRACK  = 6'd19;
  localparam logic [5:0] K_RBRACK  = 6'd20;
  localparam logic [5:0] K_COMMA   = 6'd21;
  localparam logic [5:0] K_SEMI    = 6'd22;
  localparam logic [5:0] K_PLUS    = 6'd23;
  localparam logic [5:0] K_MINUS   = 6'd25;
  localparam logic [5:0] K_STAR    = 6'd26;
  localparam logic [5:0] K_SLASH   = 6'd27;
  localparam logic [5:0] K_BANG    = 6'd28;
  localparam logic [5:0] K_ASSIGN  = 6'd30;
  localparam logic [5:0] K_GT      = 6'd32;
  localparam logic [5:0] K_LT      = 6'd34;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;

  // keyword text, first character in the low byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_6573_6c65,  // else
    64'h0000_0065_736c_6166,  // false
    64'h6e6f_6974_636e_7566,  // function
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_0074_656c,  // let
    64'h0000_0000_6c6c_756e,  // null
    64'h0000_6e72_7574_6572,  // return
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_6c69_6877   // while
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd8, 4'd2, 4'd3, 4'd4, 4'd6, 4'd4, 4'd5
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      CH_LPAR:  k = K_LPAREN;
      CH_RPAR:  k = K_RPAREN;
      CH_LBRC:  k = K_LBRACE;
      CH_RBRC:  k = K_RBRACE;
      CH_LBRK:  k = K_LBRACK;
      CH_RBRK:  k = K_RBRACK;
      CH_COMMA: k = K_COMMA;
      CH_SEMI:  k = K_SEMI;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_STAR;
      default:  k = K_EOF;
    endcase
    return k;
  endfunction

  // one-character kind of an operator that may take '='; the two-character kind is one more
  function automatic logic [5:0] op_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      CH_PLUS: k = K_PLUS;
      CH_BANG: k = K_BANG;
      CH_EQ:   k = K_ASSIGN;
      CH_GT:   k = K_GT;
      CH_LT:   k = K_LT;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  // len_ok is low when the word is longer than any keyword
  function automatic logic [5:0] word_kind(input logic [63:0] p, input logic [3:0] len,
                                           input logic len_ok);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (len_ok && (len == KW_LEN[i]) && (p == KW_TEXT[i])) begin
        k = K_KW_BASE + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ hdl/source_byte_tokenizer_core.sv @@
// source byte tokenizer: scan state machine and token output buffer
// an accepted byte waits in the input register; scanning it writes its tokens to the buffer
// throughput: one byte per cycle while token_stall is low and each byte yields at most one
//   token; a byte with more tokens (up to three) holds the input register while they drain
// reset: synchronous rst clears the scan state and byte position and empties both buffers
// the end byte (0) also returns the scan state and byte position to their reset values
module source_byte_tokenizer_core #(
  parameter int OFFSET_BITS   = sbt_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_BYTES = sbt_pkg::KEYWORD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        source_valid,
  output logic        source_stall,
  input  logic [7:0]  source_byte,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [5:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] lexeme_length,
  output logic        last_of_run
);
  import sbt_pkg::*;

  localparam int OB  = OFFSET_BITS;
  localparam int KIW = $clog2(KEYWORD_BYTES);
  localparam logic [OB-1:0] KB_LEN = OB'(KEYWORD_BYTES);
  localparam logic [OB-1:0] ONE    = OB'(1);
  localparam logic [OB-1:0] TWO    = OB'(2);

  function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a, input logic [OB-1:0] b);
    logic [OB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OB] ? {OB{1'b1}} : s[OB-1:0];
  endfunction

  function automatic logic [15:0] clamp16(input logic [OB-1:0] a);
    logic [32:0] v;
    v = 33'(a);
    return (v > 33'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // scan state
  scan_mode_t    mode, mode_next;
  logic [7:0]    pending, pending_next;
  logic [OB-1:0] tok_start, tok_start_next;
  logic [OB-1:0] pos, pos_next;
  logic [OB-1:0] wlen, wlen_next;
  logic [7:0]    prefix [KEYWORD_BYTES];
  logic [7:0]    prefix_next [KEYWORD_BYTES];

  // token buffer, slot 0 is the head
  token_t     slot [MAX_RESULTS];
  logic [1:0] count;

  token_t     res_set [MAX_RESULTS];
  logic [1:0] res_count;

  logic       take, scan_go;
  logic       ident_ch, digit_ch, run_idle;
  logic [5:0] pend_kind;
  logic [63:0] prefix8;

  assign take     = (count != 2'd0) && !token_stall;
  assign scan_go  = in_valid && ((count == 2'd0) || ((count == 2'd1) && take));
  assign source_stall = in_valid && !scan_go;

  assign token_valid   = (count != 2'd0);
  assign token_kind    = slot[0].kind;
  assign start_offset  = slot[0].start;
  assign lexeme_length = slot[0].len;
  assign last_of_run   = slot[0].last;

  assign ident_ch  = is_alpha(in_byte) || is_digit(in_byte) || (in_byte == CH_UNDER);
  assign digit_ch  = is_digit(in_byte);
  assign pend_kind = op_kind(pending);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      prefix8[8*i +: 8] = prefix[i];
    end
  end

  // whether the byte falls through to the idle-state handling
  always_comb begin
    case (mode)
      M_IDENT:   run_idle = !ident_ch;
      M_INT:     run_idle = !digit_ch && (in_byte != CH_DOT);
      M_DOT:     run_idle = !digit_ch;
      M_FRAC:    run_idle = !digit_ch;
      M_STR:     run_idle = (in_byte == CH_END);
      M_SLASH:   run_idle = (in_byte != CH_SLASH);
      M_COMMENT: run_idle = (in_byte == CH_END);
      M_OP:      run_idle = !((in_byte == CH_EQ) && (pend_kind != K_EOF));
      default:   run_idle = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    mode_next      = mode;
    pending_next   = pending;
    tok_start_next = tok_start;
    wlen_next      = wlen;
    prefix_next    = prefix;
    case (mode)
      M_IDENT: begin
        if (ident_ch) begin
          if (wlen < KB_LEN) begin
            prefix_next[wlen[KIW-1:0]] = in_byte;
          end
          wlen_next = sat_add(wlen, ONE);
        end
      end
      M_INT: begin
        if (digit_ch) begin
          wlen_next = sat_add(wlen, ONE);
        end else if (in_byte == CH_DOT) begin
          mode_next = M_DOT;
        end
      end
      M_DOT: begin
        if (digit_ch) begin
          wlen_next = sat_add(wlen, TWO);
          mode_next = M_FRAC;
        end
      end
      M_FRAC: begin
        if (digit_ch) begin
          wlen_next = sat_add(wlen, ONE);
        end
      end
      M_STR: begin
        if ((in_byte == CH_QUOTE) || (in_byte == CH_NL)) begin
          mode_next = M_IDLE;
        end else if (in_byte != CH_END) begin
          wlen_next = sat_add(wlen, ONE);
        end
      end
      M_SLASH: begin
        if (in_byte == CH_SLASH) begin
          mode_next = M_COMMENT;
        end
      end
      M_COMMENT: begin
        if (in_byte == CH_NL) begin
          mode_next = M_IDLE;
        end
      end
      M_OP: begin
        mode_next = M_IDLE;
      end
      default: begin
        mode_next = M_IDLE;
      end
    endcase

    if (run_idle) begin
      mode_next = M_IDLE;
      if ((in_byte == CH_END) || is_space(in_byte)) begin
        mode_next = M_IDLE;
      end else if (in_byte == CH_SLASH) begin
        mode_next      = M_SLASH;
        tok_start_next = pos;
      end else if (is_alpha(in_byte) || (in_byte == CH_UNDER)) begin
        mode_next      = M_IDENT;
        tok_start_next = pos;
        for (int i = 0; i < KEYWORD_BYTES; i++) begin
          prefix_next[i] = 8'h00;
        end
        prefix_next[0] = in_byte;
        wlen_next      = ONE;
      end else if (digit_ch) begin
        mode_next      = M_INT;
        tok_start_next = pos;
        wlen_next      = ONE;
      end else if (in_byte == CH_QUOTE) begin
        mode_next      = M_STR;
        tok_start_next = sat_add(pos, ONE);
        wlen_next      = '0;
      end else if (op_kind(in_byte) != K_EOF) begin
        mode_next      = M_OP;
        pending_next   = in_byte;
        tok_start_next = pos;
      end
    end

    // end of source returns the scan state and byte position to reset values
    if (in_byte == CH_END) begin
      mode_next      = M_IDLE;
      pending_next   = 8'h00;
      tok_start_next = '0;
      wlen_next      = '0;
      pos_next       = '0;
      for (int i = 0; i < KEYWORD_BYTES; i++) begin
        prefix_next[i] = 8'h00;
      end
    end else begin
      pos_next = sat_add(pos, ONE);
    end
  end

  // tokens caused by the byte
  always_comb begin
    logic [5:0] k;
    logic [1:0] n;
    n = 2'd0;
    k = K_EOF;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_set[i] = '0;
    end
    case (mode)
      M_IDENT: begin
        if (!ident_ch) begin
          res_set[n] = '{word_kind(prefix8, wlen[3:0], wlen <= OB'(8)),
                         clamp16(tok_start), clamp16(wlen), 1'b0};
          n = n + 2'd1;
        end
      end
      M_INT, M_FRAC: begin
        if (run_idle) begin
          res_set[n] = '{K_NUMBER, clamp16(tok_start), clamp16(wlen), 1'b0};
          n = n + 2'd1;
        end
      end
      M_DOT: begin
        // a dot with no digit after it ends the number and stands alone
        if (!digit_ch) begin
          res_set[n] = '{K_NUMBER, clamp16(tok_start), clamp16(wlen), 1'b0};
          n = n + 2'd1;
          res_set[n] = '{K_UNEXP, clamp16(sat_add(tok_start, wlen)), 16'd1, 1'b0};
          n = n + 2'd1;
        end
      end
      M_STR: begin
        if (in_byte == CH_QUOTE) begin
          res_set[n] = '{K_STRING, clamp16(tok_start), clamp16(wlen), 1'b0};
          n = n + 2'd1;
        end else if ((in_byte == CH_NL) || (in_byte == CH_END)) begin
          res_set[n] = '{K_UNTERM, clamp16(tok_start), clamp16(wlen), 1'b0};
          n = n + 2'd1;
        end
      end
      M_SLASH: begin
        if (in_byte != CH_SLASH) begin
          res_set[n] = '{K_SLASH, clamp16(tok_start), 16'd1, 1'b0};
          n = n + 2'd1;
        end
      end
      M_OP: begin
        k = (pend_kind == K_EOF) ? K_UNEXP : pend_kind;
        if (run_idle) begin
          res_set[n] = '{k, clamp16(tok_start), 16'd1, 1'b0};
        end else begin
          res_set[n] = '{k + 6'd1, clamp16(tok_start), 16'd2, 1'b0};
        end
        n = n + 2'd1;
      end
      default: begin
        n = 2'd0;
      end
    endcase

    if (run_idle) begin
      if (in_byte == CH_END) begin
        res_set[n] = '{K_EOF, clamp16(pos), 16'd0, 1'b0};
        n = n + 2'd1;
      end else if (is_space(in_byte) || (in_byte == CH_SLASH) || ident_ch ||
                   (in_byte == CH_QUOTE) || (op_kind(in_byte) != K_EOF)) begin
        n = n;
      end else if (single_kind(in_byte) != K_EOF) begin
        res_set[n] = '{single_kind(in_byte), clamp16(pos), 16'd1, 1'b0};
        n = n + 2'd1;
      end else begin
        res_set[n] = '{K_UNEXP, clamp16(pos), 16'd1, 1'b0};
        n = n + 2'd1;
      end
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_set[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
    res_count = n;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      count     <= 2'd0;
      mode      <= M_IDLE;
      pending   <= 8'h00;
      tok_start <= '0;
      pos       <= '0;
      wlen      <= '0;
      for (int i = 0; i < KEYWORD_BYTES; i++) begin
        prefix[i] <= 8'h00;
      end
    end else begin
      if (source_valid && !source_stall) begin
        in_valid <= 1'b1;
      end else if (scan_go) begin
        in_valid <= 1'b0;
      end
      if (scan_go) begin
        count     <= res_count;
        mode      <= mode_next;
        pending   <= pending_next;
        tok_start <= tok_start_next;
        pos       <= pos_next;
        wlen      <= wlen_next;
        prefix    <= prefix_next;
      end else if (take) begin
        count <= count - 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (source_valid && !source_stall) begin
      in_byte <= source_byte;
    end
    if (scan_go) begin
      slot <= res_set;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

@@ tb/tb.sv @@
// self-checking testbench for source_byte_tokenizer_core: token prediction and scoreboard
`timescale 1ns / 1ps

module tb;
  import sbt_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_SRC,
    PH_SNK,
    PH_BOTH
  } pace_t;

  typedef struct {
    logic [7:0] b;
    pace_t      pace;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        source_valid = 1'b0;
  logic        source_stall;
  logic [7:0]  source_byte = 8'h00;
  logic        token_valid;
  logic        token_stall = 1'b0;
  logic [5:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] lexeme_length;
  logic        last_of_run;

  src_item_t   pend_q[$];
  token_t      token_fifo[$];
  token_t      run_toks[$];
  pace_t       fill_pace = PH_NONE;
  pace_t       cur_pace = PH_NONE;
  int          mismatches = 0;
  int          idle_cycles = 0;

  // scanner state mirrored from the block
  scan_mode_t  mode = M_IDLE;
  logic [7:0]  pend_op = 8'h00;
  logic [15:0] tok_start = 16'h0000;
  logic [15:0] byte_pos = 16'h0000;
  logic [7:0]  prefix [8] = '{default: 8'h00};
  logic [15:0] word_len = 16'h0000;

  string kw_words [9] = '{"else", "false", "function", "if", "let", "null", "return",
                          "true", "while"};

  source_byte_tokenizer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .source_valid (source_valid),
    .source_stall (source_stall),
    .source_byte  (source_byte),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .lexeme_length(lexeme_length),
    .last_of_run  (last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic alpha_ch(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // one-character kind of an operator that can pair with '='
  function automatic logic [5:0] op_one_kind(input logic [7:0] c);
    case (c)
      CH_PLUS: return K_PLUS;
      CH_BANG: return K_BANG;
      CH_EQ:   return K_ASSIGN;
      CH_GT:   return K_GT;
      CH_LT:   return K_LT;
      default: return K_EOF;
    endcase
  endfunction

  function automatic void add_tok(input logic [5:0] kind, input logic [15:0] start,
                                  input logic [15:0] len);
    token_t t;
    t.kind = kind;
    t.start = start;
    t.len = len;
    t.last = 1'b0;
    run_toks.push_back(t);
  endfunction

  // advance the mirrored scanner by one byte and queue the tokens it produces
  task automatic scan_byte(input logic [7:0] c);
    logic [15:0] here;
    logic        again;
    logic        hit;
    logic [5:0]  k;
    here = byte_pos;
    run_toks.delete();
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (mode)
        M_IDENT: begin
          if (alpha_ch(c) || digit_ch(c) || c == CH_UNDER) begin
            if (word_len < 8) prefix[word_len[2:0]] = c;
            word_len = sat_add(word_len, 16'd1);
          end else begin
            k = K_IDENT;
            for (int i = 0; i < 9; i++) begin
              if (k == K_IDENT && word_len == kw_words[i].len()) begin
                hit = 1'b1;
                for (int j = 0; j < kw_words[i].len(); j++) begin
                  if (prefix[j] != kw_words[i][j]) hit = 1'b0;
                end
                if (hit) k = K_KW_BASE + 6'(i);
              end
            end
            add_tok(k, tok_start, word_len);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_INT: begin
          if (digit_ch(c)) begin
            word_len = sat_add(word_len, 16'd1);
          end else if (c == CH_DOT) begin
            mode = M_DOT;
          end else begin
            add_tok(K_NUMBER, tok_start, word_len);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_DOT: begin
          if (digit_ch(c)) begin
            word_len = sat_add(word_len, 16'd2);
            mode = M_FRAC;
          end else begin
            // the dot did not start a fraction: number, then the dot as a stray char
            add_tok(K_NUMBER, tok_start, word_len);
            add_tok(K_UNEXP, sat_add(tok_start, word_len), 16'd1);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_FRAC: begin
          if (digit_ch(c)) begin
            word_len = sat_add(word_len, 16'd1);
          end else begin
            add_tok(K_NUMBER, tok_start, word_len);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            add_tok(K_STRING, tok_start, word_len);
            mode = M_IDLE;
          end else if (c == CH_NL) begin
            add_tok(K_UNTERM, tok_start, word_len);
            mode = M_IDLE;
          end else if (c == CH_END) begin
            add_tok(K_UNTERM, tok_start, word_len);
            mode = M_IDLE;
            again = 1'b1;
          end else begin
            word_len = sat_add(word_len, 16'd1);
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode = M_COMMENT;
          end else begin
            add_tok(K_SLASH, tok_start, 16'd1);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_NL) begin
            mode = M_IDLE;
          end else if (c == CH_END) begin
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        M_OP: begin
          k = op_one_kind(pend_op);
          if (k == K_EOF) k = K_UNEXP;
          if (c == CH_EQ && k != K_UNEXP) begin
            add_tok(k + 6'd1, tok_start, 16'd2);
            mode = M_IDLE;
          end else begin
            add_tok(k, tok_start, 16'd1);
            mode = M_IDLE;
            again = 1'b1;
          end
        end
        default: begin
          mode = M_IDLE;
          if (c == CH_END) begin
            add_tok(K_EOF, here, 16'd0);
          end else if (c == CH_SPACE || c == CH_CR || c == CH_TAB || c == CH_NL) begin
            // whitespace
          end else if (c == CH_SLASH) begin
            mode = M_SLASH;
            tok_start = here;
          end else if (alpha_ch(c) || c == CH_UNDER) begin
            mode = M_IDENT;
            tok_start = here;
            prefix = '{default: 8'h00};
            prefix[0] = c;
            word_len = 16'd1;
          end else if (digit_ch(c)) begin
            mode = M_INT;
            tok_start = here;
            word_len = 16'd1;
          end else if (c == CH_QUOTE) begin
            mode = M_STR;
            tok_start = sat_add(here, 16'd1);
            word_len = 16'd0;
          end else if (op_one_kind(c) != K_EOF) begin
            mode = M_OP;
            pend_op = c;
            tok_start = here;
          end else begin
            case (c)
              CH_LPAR:  add_tok(K_LPAREN, here, 16'd1);
              CH_RPAR:  add_tok(K_RPAREN, here, 16'd1);
              CH_LBRC:  add_tok(K_LBRACE, here, 16'd1);
              CH_RBRC:  add_tok(K_RBRACE, here, 16'd1);
              CH_LBRK:  add_tok(K_LBRACK, here, 16'd1);
              CH_RBRK:  add_tok(K_RBRACK, here, 16'd1);
              CH_COMMA: add_tok(K_COMMA, here, 16'd1);
              CH_SEMI:  add_tok(K_SEMI, here, 16'd1);
              CH_MINUS: add_tok(K_MINUS, here, 16'd1);
              CH_STAR:  add_tok(K_STAR, here, 16'd1);
              default:  add_tok(K_UNEXP, here, 16'd1);
            endcase
          end
        end
      endcase
    end
    if (c == CH_END) begin
      mode = M_IDLE;
      pend_op = 8'h00;
      tok_start = 16'h0000;
      byte_pos = 16'h0000;
      prefix = '{default: 8'h00};
      word_len = 16'h0000;
    end else begin
      byte_pos = sat_add(here, 16'd1);
    end
    if (run_toks.size() != 0) run_toks[run_toks.size() - 1].last = 1'b1;
    foreach (run_toks[i]) token_fifo.push_back(run_toks[i]);
  endtask

  task automatic push_byte(input logic [7:0] b);
    src_item_t it;
    it.b = b;
    it.pace = fill_pace;
    pend_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // sender: holds a stalled byte, otherwise presents the next one or idles
  always @(posedge clk) begin : drive_b
    int        gap;
    logic      idle;
    src_item_t nxt;
    if (!rst) begin
      if (source_valid && !source_stall) scan_byte(source_byte);
      if (!source_valid || !source_stall) begin
        gap = $urandom_range(0, 99);
        idle = 1'b1;
        if (pend_q.size() != 0) begin
          nxt = pend_q[0];
          idle = (nxt.pace == PH_SRC && gap < 68) || (nxt.pace == PH_BOTH && gap < 29);
          cur_pace <= nxt.pace;
        end
        if (!idle) begin
          source_byte <= nxt.b;
          source_valid <= 1'b1;
          void'(pend_q.pop_front());
        end else begin
          source_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall and token compare against the oldest prediction
  always @(posedge clk) begin : mon_b
    int     r;
    token_t want;
    r = $urandom_range(0, 99);
    if (!rst && token_valid && !token_stall) begin
      if (token_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d start %0d len %0d last %0b",
                   token_kind, start_offset, lexeme_length, last_of_run);
      end else begin
        want = token_fifo.pop_front();
        if (want.kind !== token_kind || want.start !== start_offset ||
            want.len !== lexeme_length || want.last !== last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"token mismatch: expected kind %0d start %0d len %0d last %0b,",
                      " got kind %0d start %0d len %0d last %0b"},
                     want.kind, want.start, want.len, want.last,
                     token_kind, start_offset, lexeme_length, last_of_run);
        end
      end
    end
    token_stall <= (cur_pace == PH_SNK && r < 68) || (cur_pace == PH_BOTH && r < 29);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((source_valid && !source_stall) || (token_valid && !token_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    string      id_chars;
    string      op_chars;
    string      punct_chars;
    int         target;
    int         n;
    logic [7:0] b;
    id_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    op_chars = "+!=<>";
    punct_chars = "(){}[],;-*/";

    // directed: dot after number, operator at end, unterminated strings, high bytes,
    // comment, lone slash, dot then end
    fill_pace = PH_NONE;
    push_text("7.;>");
    push_byte(CH_END);
    push_text("\"q");
    push_byte(CH_END);
    push_text("\"z\n");
    push_byte(8'hff);
    push_byte(8'h80);
    push_text("//c\n/x1.");
    push_byte(CH_END);
    push_text("x=");
    push_byte(CH_END);

    // random token streams, one pacing phase each
    for (int p = 0; p < 4; p++) begin
      fill_pace = pace_t'(p);
      target = pend_q.size() + 32;
      while (pend_q.size() < target) begin
        case ($urandom_range(0, 11))
          0, 1: begin
            n = $urandom_range(1, 11);
            push_byte(id_chars[$urandom_range(0, 52)]);
            for (int i = 1; i < n; i++) push_byte(id_chars[$urandom_range(0, 62)]);
          end
          2: push_text(kw_words[$urandom_range(0, 8)]);
          3: begin
            repeat ($urandom_range(1, 4)) push_byte(8'("0" + $urandom_range(0, 9)));
            n = $urandom_range(0, 9);
            if (n < 7) begin
              push_byte(CH_DOT);
              repeat ($urandom_range(1, 3)) push_byte(8'("0" + $urandom_range(0, 9)));
            end else if (n == 7) begin
              push_byte(CH_DOT);
            end
          end
          4: begin
            push_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
              do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_NL);
              push_byte(b);
            end
            push_byte(($urandom_range(0, 99) < 85) ? CH_QUOTE : CH_NL);
          end
          5, 6: begin
            push_byte(op_chars[$urandom_range(0, 4)]);
            if ($urandom_range(0, 1) == 1) push_byte(CH_EQ);
          end
          7: push_byte(punct_chars[$urandom_range(0, 10)]);
          8: begin
            push_text("//");
            repeat ($urandom_range(0, 4)) begin
              do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
              push_byte(b);
            end
            push_byte(CH_NL);
          end
          9: begin
            case ($urandom_range(0, 3))
              0: push_byte(CH_SPACE);
              1: push_byte(CH_TAB);
              2: push_byte(CH_CR);
              default: push_byte(CH_NL);
            endcase
          end
          10: push_byte(8'($urandom_range(1, 255)));
          default: if ($urandom_range(0, 3) == 0) push_byte(CH_END);
        endcase
        // adjacent tokens exercise the one-byte lookahead
        if ($urandom_range(0, 99) < 40) push_byte(CH_SPACE);
      end
      push_byte(CH_END);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || source_valid) @(negedge clk);
    while (token_fifo.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && token_fifo.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sbt_pkg.sv
hdl/source_byte_tokenizer_core.sv
tb/tb.sv
